// ===== sv/tp_pkg.sv =====
// ----------------------------------------------------------------------------
// tp_pkg
// Shared types and constants of the threshold projection pipeline.
// ----------------------------------------------------------------------------
package tp_pkg;

	// one in Q1.16
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	// slope saturation value, Q9.16
	localparam logic [24:0] SLOPE_MAX = 25'h1FF_FFFF;
	// exp(-1) in Q0.32 as produced by the series and reciprocal
	localparam logic [30:0] E1_Q32    = 31'd1580030172;

	// register addresses (word select bit)
	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_STEEP  = 1'b1;

	// sideband that travels with every transaction
	typedef struct packed {
		logic        tok;    // internal transaction that computes exp(-beta)
		logic        neg;    // sample below zero
		logic        over;   // sample above one
		logic        lower;  // sample at or below the threshold
		logic        sat;    // exponent argument too large, exp is zero
		logic [15:0] d;      // distance from the threshold
		logic [4:0]  n;      // integer part of the exponent argument
	} side_t;

	// series accumulation state
	typedef struct packed {
		side_t       side;
		logic [15:0] f;
		logic [31:0] sum;
	} tay_t;

endpackage

// ===== sv/tp_arg.sv =====
// ----------------------------------------------------------------------------
// tp_arg
// Classifies the sample and computes the exponent argument
// t = round(beta * d * 256 / den) with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module tp_arg import tp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic               in_tok,
	input  logic signed [19:0] x,
	input  logic [15:0]        eta,
	input  logic [15:0]        beta,
	output logic               out_vld,
	output side_t              out_side,
	output logic [15:0]        out_frac
);

	logic        neg_c, over_c, lower_c;
	logic [16:0] xu_c, s17_c, w17_c;
	logic [15:0] r_c, d_c, den_c;
	side_t       side_c;

	logic        vld_s1, vld_s2;
	side_t       side_s1, side_s2;
	logic [15:0] den_s1, den_s2;
	logic [31:0] prod_s2;
	logic [40:0] num_c;
	side_t       side_sat_c;

	logic        dv_vld [0:21];
	side_t       dv_side [0:21];
	logic [15:0] dv_den [0:21];
	logic [40:0] dv_rem [0:21];
	logic [20:0] dv_q [0:21];

	// classify the sample
	assign neg_c   = x[19];
	assign over_c  = !x[19] && (x[18:0] > 19'(ONE_Q16));
	assign xu_c    = x[16:0];
	assign lower_c = xu_c <= {1'b0, eta};
	assign r_c     = eta - xu_c[15:0];
	assign s17_c   = xu_c - {1'b0, eta};
	assign w17_c   = ONE_Q16 - {1'b0, eta};
	assign d_c     = in_tok ? 16'd1 : (lower_c ? r_c : s17_c[15:0]);
	assign den_c   = in_tok ? 16'd1 : (lower_c ? eta : w17_c[15:0]);

	always_comb begin
		side_c       = '0;
		side_c.tok   = in_tok;
		side_c.neg   = neg_c;
		side_c.over  = over_c;
		side_c.lower = lower_c;
		side_c.d     = d_c;
	end

	// rounded numerator
	assign num_c = {1'b0, prod_s2, 8'd0} + {26'd0, den_s2[15:1]};

	// quotient overflow flag joins the sideband
	always_comb begin
		side_sat_c     = side_s2;
		side_sat_c.sat = num_c[40:21] >= {4'd0, den_s2};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			dv_vld[0] <= 1'b0;
		end else begin
			vld_s1    <= in_vld;
			vld_s2    <= vld_s1;
			dv_vld[0] <= vld_s2;
		end
	end

	// entry, product and numerator stages
	always_ff @(posedge clk) begin
		side_s1     <= side_c;
		den_s1      <= den_c;
		side_s2     <= side_s1;
		den_s2      <= den_s1;
		prod_s2     <= beta * side_s1.d;
		dv_side[0]  <= side_sat_c;
		dv_den[0]   <= den_s2;
		dv_rem[0]   <= num_c;
		dv_q[0]     <= '0;
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < 21; j++) begin : g_div
		logic [40:0] dsh;
		logic        ge;
		assign dsh = 41'(dv_den[j]) << (20 - j);
		assign ge  = dv_rem[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[j+1] <= 1'b0;
			end else begin
				dv_vld[j+1] <= dv_vld[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_side[j+1] <= dv_side[j];
			dv_den[j+1]  <= dv_den[j];
			dv_rem[j+1]  <= ge ? (dv_rem[j] - dsh) : dv_rem[j];
			dv_q[j+1]    <= {dv_q[j][19:0], ge};
		end
	end

	// split the argument into integer and fraction
	assign out_vld  = dv_vld[21];
	assign out_frac = dv_q[21][15:0];
	always_comb begin
		out_side   = dv_side[21];
		out_side.n = dv_q[21][20:16];
	end

endmodule

// ===== sv/tp_expf.sv =====
// ----------------------------------------------------------------------------
// tp_expf
// exp(-f) for a 16-bit fraction f: truncated series of exp(f) in Q.30,
// then a pipelined reciprocal giving Q0.32.
// ----------------------------------------------------------------------------
module tp_expf import tp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [15:0] in_frac,
	output logic        out_vld,
	output side_t       out_side,
	output logic [32:0] out_val
);

	// series state after each term
	logic        tv [0:19];
	tay_t        tc [0:19];
	logic [30:0] tm [0:19];

	// per-term intermediate stages
	logic        av [0:18];
	tay_t        ac [0:18];
	logic [30:0] ap [0:18];
	logic        bv [0:18];
	tay_t        bc [0:18];
	logic [30:0] bp [0:18];
	logic [30:0] bq [0:18];

	// reciprocal divider
	logic        rv [1:33];
	side_t       rs [1:33];
	logic [31:0] rd [1:33];
	logic [63:0] rr [1:33];
	logic [32:0] rq [1:33];

	tay_t in_tay;
	always_comb begin
		in_tay      = '0;
		in_tay.side = in_side;
		in_tay.f    = in_frac;
		in_tay.sum  = 32'h4000_0000 + {2'd0, in_frac, 14'd0};
	end

	// first term is f itself scaled to Q.30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv[0] <= 1'b0;
		end else begin
			tv[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tc[0] <= in_tay;
		tm[0] <= {1'b0, in_frac, 14'd0};
	end

	// terms two to twenty: multiply, reciprocal multiply, correct
	for (genvar g = 0; g < 19; g++) begin : g_term
		localparam int          K   = g + 2;
		localparam logic [31:0] RCP = 32'((64'd1 << 32) / K);
		logic [46:0] pr;
		logic [62:0] mr;
		logic [30:0] rm, qn;
		tay_t        nx;

		assign pr = 47'(tm[g]) * 47'(tc[g].f);
		assign mr = 63'(ap[g]) * 63'(RCP);
		assign rm = bp[g] - (bq[g] * 31'(K));
		assign qn = (rm >= 31'(K)) ? (bq[g] + 31'd1) : bq[g];

		// running sum with the new term
		always_comb begin
			nx     = bc[g];
			nx.sum = bc[g].sum + {1'b0, qn};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av[g]   <= 1'b0;
				bv[g]   <= 1'b0;
				tv[g+1] <= 1'b0;
			end else begin
				av[g]   <= tv[g];
				bv[g]   <= av[g];
				tv[g+1] <= bv[g];
			end
		end

		always_ff @(posedge clk) begin
			ac[g]   <= tc[g];
			ap[g]   <= pr[46:16];
			bc[g]   <= ac[g];
			bp[g]   <= ap[g];
			bq[g]   <= mr[62:32];
			tc[g+1] <= nx;
			tm[g+1] <= qn;
		end
	end

	// reciprocal (2^62 + sum/2) / sum, one quotient bit per stage
	for (genvar i = 0; i < 33; i++) begin : g_rcp
		logic        sv_c;
		side_t       ss_c;
		logic [31:0] sd_c;
		logic [63:0] sr_c;
		logic [32:0] sq_c;
		logic [63:0] dsh;
		logic        ge;

		if (i == 0) begin : g_src0
			assign sv_c = tv[19];
			assign ss_c = tc[19].side;
			assign sd_c = tc[19].sum;
			assign sr_c = {2'b01, 31'd0, tc[19].sum[31:1]};
			assign sq_c = '0;
		end else begin : g_srcn
			assign sv_c = rv[i];
			assign ss_c = rs[i];
			assign sd_c = rd[i];
			assign sr_c = rr[i];
			assign sq_c = rq[i];
		end

		assign dsh = 64'(sd_c) << (32 - i);
		assign ge  = sr_c >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv[i+1] <= 1'b0;
			end else begin
				rv[i+1] <= sv_c;
			end
		end

		always_ff @(posedge clk) begin
			rs[i+1] <= ss_c;
			rd[i+1] <= sd_c;
			rr[i+1] <= ge ? (sr_c - dsh) : sr_c;
			rq[i+1] <= {sq_c[31:0], ge};
		end
	end

	assign out_vld  = rv[33];
	assign out_side = rs[33];
	assign out_val  = rq[33];

endmodule

// ===== sv/tp_pow.sv =====
// ----------------------------------------------------------------------------
// tp_pow
// Applies the integer part of the argument: up to 31 rounded multiplies
// by exp(-1), one per stage; a saturated argument gives zero.
// ----------------------------------------------------------------------------
module tp_pow import tp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [32:0] in_val,
	output logic        out_vld,
	output side_t       out_side,
	output logic [32:0] out_val
);

	logic        pv [1:32];
	side_t       ps [1:32];
	logic [32:0] pw [1:32];

	for (genvar i = 0; i < 32; i++) begin : g_mul
		logic        sv_c;
		side_t       ss_c;
		logic [32:0] sw_c;
		logic [63:0] pr;
		logic [63:0] rn;

		if (i == 0) begin : g_src0
			assign sv_c = in_vld;
			assign ss_c = in_side;
			assign sw_c = in_side.sat ? 33'd0 : in_val;
		end else begin : g_srcn
			assign sv_c = pv[i];
			assign ss_c = ps[i];
			assign sw_c = pw[i];
		end

		// rounded product with exp(-1)
		assign pr = 64'(sw_c) * 64'(E1_Q32);
		assign rn = pr + 64'h8000_0000;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv[i+1] <= 1'b0;
			end else begin
				pv[i+1] <= sv_c;
			end
		end

		always_ff @(posedge clk) begin
			ps[i+1] <= ss_c;
			pw[i+1] <= (5'(i) < ss_c.n) ? {1'b0, rn[63:32]} : sw_c;
		end
	end

	assign out_vld  = pv[32];
	assign out_side = ps[32];
	assign out_val  = pw[32];

endmodule

// ===== sv/tp_out.sv =====
// ----------------------------------------------------------------------------
// tp_out
// Combines exp terms into projected density and slope, rounds, clamps
// and drives the result registers.
// ----------------------------------------------------------------------------
module tp_out import tp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [32:0] a,
	input  logic [32:0] c,
	input  logic [15:0] eta,
	input  logic [15:0] beta,
	output logic        done,
	output logic [16:0] density_out,
	output logic [24:0] slope_out
);

	logic [16:0] w17_c;
	logic [15:0] mlt_c;
	logic [32:0] am_c;

	logic        vld_s1;
	side_t       side_s1;
	logic [48:0] pa_s1, pc_s1, pb_s1;

	logic [51:0] acc_c, rnd_c;
	logic [19:0] dr_c;
	logic [16:0] dens_c;
	logic [50:0] ss_c;
	logic [26:0] sl_c;
	logic [24:0] slope_c;

	logic        done_s2;
	logic [16:0] dens_s2;
	logic [24:0] slope_s2;

	// products
	assign w17_c = ONE_Q16 - {1'b0, eta};
	assign mlt_c = in_side.lower ? eta : w17_c[15:0];
	assign am_c  = in_side.lower ? a : (33'h1_0000_0000 - a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			done_s2 <= vld_s1 && !side_s1.tok;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		pa_s1   <= 49'(mlt_c) * 49'(am_c);
		pc_s1   <= 49'(in_side.d) * 49'(c);
		pb_s1   <= 49'(beta) * 49'(a);
	end

	// density accumulate, round, clamp
	always_comb begin
		if (side_s1.lower) begin
			acc_c = {3'd0, pa_s1} - {3'd0, pc_s1};
		end else begin
			acc_c = {3'd0, pa_s1} + {3'd0, pc_s1} + {4'd0, eta, 32'd0};
		end
		rnd_c = acc_c + 52'h8000_0000;
		dr_c  = rnd_c[51:32];
		if (acc_c[51]) begin
			dens_c = '0;
		end else if (dr_c > 20'(ONE_Q16)) begin
			dens_c = ONE_Q16;
		end else begin
			dens_c = dr_c[16:0];
		end
	end

	// slope round and saturate
	assign ss_c    = {2'd0, pb_s1} + {10'd0, c, 8'd0} + (51'd1 << 23);
	assign sl_c    = ss_c[50:24];
	assign slope_c = (sl_c[26:25] != 2'd0) ? SLOPE_MAX : sl_c[24:0];

	always_ff @(posedge clk) begin
		if (side_s1.neg) begin
			dens_s2  <= '0;
			slope_s2 <= '0;
		end else if (side_s1.over) begin
			dens_s2  <= ONE_Q16;
			slope_s2 <= '0;
		end else begin
			dens_s2  <= dens_c;
			slope_s2 <= slope_c;
		end
	end

	assign done        = done_s2;
	assign density_out = dens_s2;
	assign slope_out   = slope_s2;

endmodule

// ===== sv/threshold_projection.sv =====
// ----------------------------------------------------------------------------
// threshold_projection
// Exponential threshold projection of a density stream with its derivative.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------
//   input    | start && !busy            | density_in
//   result   | done, one cycle           | density_out, slope_out
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One sample per cycle while busy is low; each result follows its sample
// through the argument divider, series, reciprocal divider and exp(-1)
// multiply chain.
// After reset and after every register write, exp(-beta) is recomputed by
// an internal transaction through the same pipeline; busy stays high
// meanwhile. The result side has no backpressure.
// ----------------------------------------------------------------------------
module threshold_projection import tp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [19:0] density_in,
	output logic        done,
	output logic [16:0] density_out,
	output logic [24:0] slope_out
);

	logic [15:0] thr_q, stp_q, eta;
	logic [32:0] c_q;
	logic        pend_q, fly_q;
	logic        wr, acc, launch;

	logic        ar_vld, ex_vld, pw_vld;
	side_t       ar_side, ex_side, pw_side;
	logic [15:0] ar_frac;
	logic [32:0] ex_val, pw_val;

	// register port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd32768;
			stp_q <= 16'd256;
		end else if (wr) begin
			case (paddr[2])
				REG_THRESH: thr_q <= pwdata[15:0];
				REG_STEEP:  stp_q <= pwdata[15:0];
				default:    thr_q <= thr_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESH: prdata = {16'd0, thr_q};
			REG_STEEP:  prdata = {16'd0, stp_q};
			default:    prdata = '0;
		endcase
	end

	assign eta = (thr_q == 16'd0) ? 16'd1 : thr_q;

	// exp(-beta) refresh control
	assign launch = pend_q && !fly_q;
	assign busy   = pend_q || fly_q;
	assign acc    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
			fly_q  <= 1'b0;
		end else begin
			if (wr) begin
				pend_q <= 1'b1;
			end else if (launch) begin
				pend_q <= 1'b0;
			end
			if (launch) begin
				fly_q <= 1'b1;
			end else if (pw_vld && pw_side.tok) begin
				fly_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pw_vld && pw_side.tok) begin
			c_q <= pw_val;
		end
	end

	tp_arg u_arg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (acc || launch),
		.in_tok   (launch),
		.x        (density_in),
		.eta      (eta),
		.beta     (stp_q),
		.out_vld  (ar_vld),
		.out_side (ar_side),
		.out_frac (ar_frac)
	);

	tp_expf u_expf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ar_vld),
		.in_side  (ar_side),
		.in_frac  (ar_frac),
		.out_vld  (ex_vld),
		.out_side (ex_side),
		.out_val  (ex_val)
	);

	tp_pow u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ex_vld),
		.in_side  (ex_side),
		.in_val   (ex_val),
		.out_vld  (pw_vld),
		.out_side (pw_side),
		.out_val  (pw_val)
	);

	tp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (pw_vld),
		.in_side     (pw_side),
		.a           (pw_val),
		.c           (c_q),
		.eta         (eta),
		.beta        (stp_q),
		.done        (done),
		.density_out (density_out),
		.slope_out   (slope_out)
	);

endmodule
